// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL; reset is active low and synchronous.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_ALWAYS(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/uvsig_pkg.sv -----
`default_nettype none

package uvsig_pkg;

    localparam int BASE_W      = 20;
    localparam int IDX_W       = 21;
    localparam int DIV_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW   = 2'd2;

    // index order of one primitive; points are p0..p3 of the descriptor
    typedef enum logic [2:0] {
        PAT_QUAD_TRI,
        PAT_QUAD_LINE,
        PAT_TOP_TRI,
        PAT_BOT_TRI,
        PAT_CAP_LINE
    } t_pat;

    typedef struct packed {
        logic [BASE_W-1:0]         base;
        logic [3:0][IDX_W-1:0]     pts;
        t_pat                      pat;
        logic                      mesh_end;
    } t_desc;

    function automatic logic [3:0] pat_len(input t_pat pat);
        logic [3:0] len;
        case (pat)
            PAT_QUAD_TRI:  len = 4'd6;
            PAT_QUAD_LINE: len = 4'd8;
            PAT_TOP_TRI:   len = 4'd3;
            PAT_BOT_TRI:   len = 4'd3;
            PAT_CAP_LINE:  len = 4'd6;
            default:       len = 4'd1;
        endcase
        return len;
    endfunction

    // point select for step k, two bits per step, step 0 in the low bits
    function automatic logic [1:0] pat_pt(input t_pat pat, input logic [2:0] k);
        logic [15:0] seq;
        case (pat)
            PAT_QUAD_TRI:  seq = 16'h03A4;  // 0 1 2 2 3 0
            PAT_QUAD_LINE: seq = 16'h3E94;  // 0 1 1 2 2 3 3 0
            PAT_TOP_TRI:   seq = 16'h0024;  // 0 1 2
            PAT_BOT_TRI:   seq = 16'h0021;  // 1 0 2
            PAT_CAP_LINE:  seq = 16'h0294;  // 0 1 1 2 2 0
            default:       seq = 16'h0000;
        endcase
        return seq[{k, 1'b0} +: 2];
    endfunction

endpackage

`default_nettype wire

// ----- src/uv_sphere_index_generator.sv -----
// Index generator for a ring-and-cap mesh (sphere or capsule). Each request on
// the slave stream asks for the next primitive and yields 3, 6 or 8 indices on
// the master stream, one per cycle unless tready stalls it (6 per quad and 3 per
// cap triangle for surfaces, 8 and 6 for wireframe). The front end takes one
// request per cycle while its 4-entry descriptor queue has room; the index sequencer
// and its output register sustain one index per cycle while tready is high. The
// first index passes the queue, the descriptor register and the output register.
// Configuration writes take effect at the next request and must be made while idle.
`default_nettype none

module uv_sphere_index_generator
    import uvsig_pkg::*;
#(
    parameter int MAX_DIVIDE = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DIV_W-1:0]     i_cfg_data,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [23:0]          i_s_axis_tdata,  // [19:0] base_vertex
    input  wire logic                 i_s_axis_tuser,  // [0] restart
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [23:0]               o_m_axis_tdata,  // [20:0] index_value
    output logic                      o_m_axis_tlast,  // last_of_primitive
    output logic                      o_m_axis_tuser   // [0] last_of_mesh
);

    logic               q_push, q_full, q_pop, q_empty;
    t_desc              q_in, q_head;
    logic [IDX_W-1:0]   out_idx;

    uvsig_front #(
        .MAX_DIVIDE (MAX_DIVIDE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_restart   (i_s_axis_tuser),
        .i_base      (i_s_axis_tdata[BASE_W-1:0]),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_in)
    );

    uvsig_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_in),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_empty     (q_empty)
    );

    uvsig_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_index (out_idx),
        .o_last  (o_m_axis_tlast),
        .o_mesh  (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {3'b000, out_idx};

endmodule

`default_nettype wire

// ----- src/uvsig_front.sv -----
`default_nettype none

module uvsig_front
    import uvsig_pkg::*;
#(
    parameter int MAX_DIVIDE = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DIV_W-1:0]     i_cfg_data,
    input  wire logic                 i_req_valid,
    output logic                      o_req_ready,
    input  wire logic                 i_restart,
    input  wire logic [BASE_W-1:0]    i_base,
    input  wire logic                 i_q_full,
    output logic                      o_q_push,
    output t_desc                     o_q_data
);

    localparam int TOTAL_MAX = 4 * MAX_DIVIDE * (2 * MAX_DIVIDE + 1);
    localparam int CW        = $clog2(TOTAL_MAX + 1);
    localparam int COLW      = $clog2(4 * MAX_DIVIDE);
    localparam logic [DIV_W-1:0] DMAX = DIV_W'((MAX_DIVIDE > 31) ? 31 : MAX_DIVIDE);

    logic [DIV_W-1:0] r_divide;
    logic             r_shape;
    logic             r_draw;
    logic [CW-1:0]    r_pc,   n_pc;
    logic [COLW-1:0]  r_col,  n_col;
    logic [CW-1:0]    r_rs,   n_rs;

    logic [DIV_W-1:0] d;
    logic [CW-1:0]    v, rings, quads, total, top;
    logic [CW-1:0]    pc, c, rs, n, pc1, a, b;
    logic             wrap, mesh_end, accept;

    assign o_req_ready = !i_q_full;
    assign accept      = i_req_valid && !i_q_full;
    assign o_q_push    = accept;

    always_comb begin
        if (r_divide == '0) begin
            d = DIV_W'(1);
        end else if (r_divide > DMAX) begin
            d = DMAX;
        end else begin
            d = r_divide;
        end
        v     = CW'({d, 2'b00});
        rings = r_shape ? CW'({d, 1'b0}) : CW'({d, 1'b0}) - CW'(1);
        quads = CW'(v * (rings - CW'(1)));
        top   = quads + v;
        total = top + v;

        wrap = i_restart || (r_pc >= total) || (CW'(r_col) >= v);
        pc   = wrap ? '0 : r_pc;
        c    = wrap ? '0 : CW'(r_col);
        rs   = wrap ? '0 : r_rs;
        n    = (c + CW'(1) == v) ? '0 : c + CW'(1);
        pc1  = pc + CW'(1);
        mesh_end = (pc1 == total);
        a = rs + c;
        b = rs + n;

        o_q_data.base     = i_base;
        o_q_data.mesh_end = mesh_end;
        o_q_data.pts[3]   = '0;
        if (pc < quads) begin
            o_q_data.pts[0] = IDX_W'(a);
            o_q_data.pts[1] = IDX_W'(a + v);
            o_q_data.pts[2] = IDX_W'(b + v);
            o_q_data.pts[3] = IDX_W'(b);
            o_q_data.pat    = r_draw ? PAT_QUAD_TRI : PAT_QUAD_LINE;
        end else if (pc < top) begin
            o_q_data.pts[0] = IDX_W'(top);
            o_q_data.pts[1] = IDX_W'(c);
            o_q_data.pts[2] = IDX_W'(n);
            o_q_data.pat    = r_draw ? PAT_TOP_TRI : PAT_CAP_LINE;
        end else begin
            // bottom pole is top + 1, last ring starts at quads
            o_q_data.pts[0] = IDX_W'(top + CW'(1));
            o_q_data.pts[1] = IDX_W'(quads + c);
            o_q_data.pts[2] = IDX_W'(quads + n);
            o_q_data.pat    = r_draw ? PAT_BOT_TRI : PAT_CAP_LINE;
        end

        if (mesh_end) begin
            n_pc  = '0;
            n_col = '0;
            n_rs  = '0;
        end else begin
            n_pc  = pc1;
            n_col = COLW'(n);
            n_rs  = rs;
            if (n == '0) begin
                if (pc1 == quads) begin
                    n_rs = '0;
                end else if (pc1 == top) begin
                    n_rs = quads;
                end else begin
                    n_rs = rs + v;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divide <= DIV_W'(4);
            r_shape  <= 1'b0;
            r_draw   <= 1'b1;
            r_pc     <= '0;
            r_col    <= '0;
            r_rs     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DIVIDE: r_divide <= i_cfg_data;
                    CFG_SHAPE:  r_shape  <= i_cfg_data[0];
                    CFG_DRAW:   r_draw   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_pc  <= n_pc;
                r_col <= n_col;
                r_rs  <= n_rs;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/uvsig_queue.sv -----
`default_nettype none

`include "assert_macros.svh"

module uvsig_queue
    import uvsig_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_desc     i_push_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_desc     o_head,
    output logic      o_empty
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_desc          r_mem [QUEUE_DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_count;

    assign o_full  = (r_count == (AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `ASSERT_ALWAYS(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")

endmodule

`default_nettype wire

// ----- src/uvsig_back.sv -----
`default_nettype none

`include "assert_macros.svh"

module uvsig_back
    import uvsig_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  t_desc                 i_head,
    input  wire logic             i_empty,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [IDX_W-1:0]      o_index,
    output logic                  o_last,
    output logic                  o_mesh
);

    t_desc              r_cur;
    logic               r_cur_valid;
    logic [2:0]         r_step;
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_last;
    logic               r_out_mesh;

    logic               step_last, fire, done;
    logic [IDX_W-1:0]   pt;

    assign step_last = ({1'b0, r_step} == pat_len(r_cur.pat) - 4'd1);
    assign fire      = r_cur_valid && (!r_out_valid || i_ready);
    assign done      = fire && step_last;
    assign o_pop     = !i_empty && (!r_cur_valid || done);
    assign pt        = r_cur.pts[pat_pt(r_cur.pat, r_step)];

    assign o_valid = r_out_valid;
    assign o_index = r_out_idx;
    assign o_last  = r_out_last;
    assign o_mesh  = r_out_mesh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cur_valid <= 1'b1;
                r_step      <= '0;
            end else if (done) begin
                r_cur_valid <= 1'b0;
            end else if (fire) begin
                r_step <= r_step + 1'b1;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
        if (fire) begin
            r_out_idx  <= IDX_W'(r_cur.base) + pt;
            r_out_last <= step_last;
            r_out_mesh <= step_last && r_cur.mesh_end;
        end
    end

    `ASSERT_ALWAYS(a_step_range, i_clk, i_rst_n, r_cur_valid,
        4'(r_step) < pat_len(r_cur.pat), "step past end of primitive")
    `ASSERT_ALWAYS(a_mesh_on_last, i_clk, i_rst_n, r_out_valid && r_out_mesh,
        r_out_last, "mesh end off primitive end")
    `ASSERT_NEXT(a_drain, i_clk, i_rst_n, done && i_empty, !r_cur_valid,
        "descriptor kept after its last index")

endmodule

`default_nettype wire

// ----- tb/sv/uv_sphere_index_generator_test.sv -----
`timescale 1ns / 1ps

module uv_sphere_index_generator_test;
    import uvsig_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_DIV     = 16;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 39;
    localparam int EXP_DEPTH   = 256;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] index_value;
        logic             last_of_prim;
        logic             last_of_mesh;
    } t_index_beat;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DIV_W-1:0]     i_cfg_data;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [23:0]          i_s_axis_tdata;  // [19:0] base_vertex
    logic                 i_s_axis_tuser;  // [0] restart
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [23:0]          o_m_axis_tdata;  // [20:0] index_value
    logic                 o_m_axis_tlast;  // last_of_primitive
    logic                 o_m_axis_tuser;  // [0] last_of_mesh

    uv_sphere_index_generator #(.MAX_DIVIDE(MAX_DIV)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // mesh configuration and walk position as the block should hold them
    logic [DIV_W-1:0] cfg_divide  = 5'd4;
    logic             cfg_capsule = 1'b0;
    logic             cfg_surface = 1'b1;
    int unsigned      prim_count  = 0;
    int unsigned      ring_col    = 0;
    int unsigned      ring_base   = 0;

    // expected results, ring buffer of 256 beats; 8-bit write and read pointers each wrap at its end
    t_index_beat expected_beats[EXP_DEPTH];
    logic [7:0]  exp_wr = '0;
    logic [7:0]  exp_rd = '0;
    t_index_beat got_beat;
    int          errors = 0;
    int          cycles = 0;

    // sender burst / receiver stall control
    bit tx_gaps       = 0;
    int tx_burst_left = 0;
    bit rx_stall      = 0;
    bit rx_state      = 1;
    int rx_left       = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_DIVIDE;
        i_cfg_data      <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= 1'b0;
        i_m_axis_tready <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!rx_stall) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_state = !rx_state;
                rx_left  = rx_state ? $urandom_range(1, 10) : $urandom_range(1, 5);
            end
            rx_left--;
            i_m_axis_tready <= rx_state;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (exp_wr == exp_rd) begin
                $display("%0t unexpected index: expected none, got %0d",
                         $time, o_m_axis_tdata);
                errors++;
            end else begin
                got_beat = expected_beats[exp_rd];
                exp_rd   = exp_rd + 8'd1;
                if (o_m_axis_tdata !== {3'b0, got_beat.index_value}) begin
                    $display("%0t index_value: expected %0d, got %0d",
                             $time, got_beat.index_value, o_m_axis_tdata);
                    errors++;
                end
                if (o_m_axis_tlast !== got_beat.last_of_prim) begin
                    $display("%0t last_of_primitive: expected %0b, got %0b",
                             $time, got_beat.last_of_prim, o_m_axis_tlast);
                    errors++;
                end
                if (o_m_axis_tuser !== got_beat.last_of_mesh) begin
                    $display("%0t last_of_mesh: expected %0b, got %0b",
                             $time, got_beat.last_of_mesh, o_m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    task automatic expect_beat(input t_index_beat beat);
        expected_beats[exp_wr] = beat;
        exp_wr = exp_wr + 8'd1;
    endtask

    // next primitive of the mesh walk -> expected indices
    task automatic predict_primitive(input bit restart, input logic [BASE_W-1:0] base);
        int unsigned d, v, rings, quads, total, last_ring, top_pole, bot_pole;
        int unsigned c, n, a, b, cnt;
        int unsigned seq[8];
        bit          mesh_end;
        t_index_beat beat;

        d = cfg_divide;
        if (d < 1) d = 1;
        if (d > MAX_DIV) d = MAX_DIV;
        v         = 4 * d;
        rings     = cfg_capsule ? 2 * d : 2 * d - 1;
        quads     = v * (rings - 1);
        total     = quads + 2 * v;
        last_ring = v * (rings - 1);
        top_pole  = v * rings;
        bot_pole  = top_pole + 1;

        // restart request, or walk position stale after a config change
        if (restart || prim_count >= total || ring_col >= v) begin
            prim_count = 0;
            ring_col   = 0;
            ring_base  = 0;
        end

        c        = ring_col;
        n        = (c + 1 == v) ? 0 : c + 1;
        mesh_end = (prim_count + 1 == total);

        if (prim_count < quads) begin
            a = ring_base + c;
            b = ring_base + n;
            if (cfg_surface) begin
                seq = '{a, a + v, b + v, b + v, b, a, 0, 0};
                cnt = 6;
            end else begin
                seq = '{a, a + v, a + v, b + v, b + v, b, b, a};
                cnt = 8;
            end
        end else if (prim_count < quads + v) begin
            if (cfg_surface) begin
                seq = '{top_pole, c, n, 0, 0, 0, 0, 0};
                cnt = 3;
            end else begin
                seq = '{top_pole, c, c, n, n, top_pole, 0, 0};
                cnt = 6;
            end
        end else begin
            if (cfg_surface) begin
                seq = '{last_ring + c, bot_pole, last_ring + n, 0, 0, 0, 0, 0};
                cnt = 3;
            end else begin
                seq = '{bot_pole, last_ring + c, last_ring + c, last_ring + n,
                        last_ring + n, bot_pole, 0, 0};
                cnt = 6;
            end
        end

        for (int k = 0; k < cnt; k++) begin
            beat.index_value  = IDX_W'(base + seq[k]);
            beat.last_of_prim = (k == cnt - 1);
            beat.last_of_mesh = (k == cnt - 1) && mesh_end;
            expect_beat(beat);
        end

        if (mesh_end) begin
            prim_count = 0;
            ring_col   = 0;
            ring_base  = 0;
        end else begin
            prim_count = (prim_count + 1) & 12'hFFF;
            ring_col   = n & 6'h3F;
            if (n == 0) begin
                if (prim_count == quads) ring_base = 0;
                else if (prim_count == quads + v) ring_base = last_ring & 12'hFFF;
                else ring_base = (ring_base + v) & 12'hFFF;
            end
        end
    endtask

    // leaves i_cfg_we high; caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIV_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_DIVIDE: cfg_divide  = data;
            CFG_SHAPE:  cfg_capsule = data[0];
            CFG_DRAW:   cfg_surface = data[0];
            default: ;
        endcase
    endtask

    task automatic set_mesh(input logic [DIV_W-1:0] divide, input bit capsule, input bit surface);
        write_reg(CFG_DIVIDE, divide);
        write_reg(CFG_SHAPE, {4'b0, capsule});
        write_reg(CFG_DRAW, {4'b0, surface});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_request(input bit restart, input logic [BASE_W-1:0] base);
        int gap;
        if (tx_gaps && tx_burst_left == 0) begin
            gap = $urandom_range(1, 6);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            tx_burst_left = $urandom_range(1, 16);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, base};
        i_s_axis_tuser  <= restart;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_primitive(restart, base);
        if (tx_burst_left > 0) tx_burst_left--;
    endtask

    // block is idle once the last index is out; small margin for the pipeline
    task automatic drain;
        i_s_axis_tvalid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [BASE_W-1:0] pick_base();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            default: return BASE_W'($urandom());
        endcase
    endfunction

    task automatic test_reset_defaults;
        send_request(1'b1, '0);
        send_request(1'b0, 20'hFFFFF);
        drain();
    endtask

    // divide above the maximum is clamped; walk position carries over
    task automatic test_clamp_high;
        tx_gaps  = 1;
        rx_stall = 1;
        set_mesh(5'd31, 1'b0, 1'b1);
        send_request(1'b0, 20'hFFFFF);
        send_request(1'b0, 20'h5A5A5);
        drain();
    endtask

    // smallest sphere in wireframe: column out of range restarts, then caps only
    task automatic test_line_caps;
        set_mesh(5'd1, 1'b0, 1'b0);
        for (int i = 0; i < 8; i++) send_request(1'b0, pick_base());
        drain();
    endtask

    // divide of zero acts as one; capsule surface over exactly one full mesh
    task automatic test_zero_divide_capsule;
        write_reg(CFG_UNUSED, 5'h1F);  // no such register; must change nothing
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        set_mesh(5'd0, 1'b1, 1'b1);
        tx_gaps  = 0;
        rx_stall = 0;
        for (int i = 0; i < 12; i++) send_request(1'b0, pick_base());
        drain();
    endtask

    task automatic test_random_walks;
        logic [DIV_W-1:0] divide;
        for (int p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(0, 9))
                0:       divide = 5'd0;
                1:       divide = DIV_W'($urandom_range(4, 16));
                2:       divide = DIV_W'($urandom_range(17, 31));
                default: divide = DIV_W'($urandom_range(1, 3));
            endcase
            set_mesh(divide, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (p == 3) write_reg(CFG_UNUSED, DIV_W'($urandom()));
            i_cfg_we <= 1'b0;
            tx_gaps  = ($urandom_range(0, 2) != 0);
            rx_stall = ($urandom_range(0, 2) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_request($urandom_range(0, 15) == 0, pick_base());
            drain();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_clamp_high();
        test_line_caps();
        test_zero_divide_capsule();
        test_random_walks();
        rx_stall = 0;
        repeat (16) @(posedge i_clk);
        if (errors == 0 && exp_wr == exp_rd) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/uvsig_pkg.sv
src/uvsig_front.sv
src/uvsig_queue.sv
src/uvsig_back.sv
src/uv_sphere_index_generator.sv
tb/sv/uv_sphere_index_generator_test.sv
